FILE: rtl/ufont_pkg.sv
package ufont_pkg;

   localparam int unsigned EscLen = 6;

   localparam logic [7:0] LeadByte  = 8'd195;
   localparam logic [7:0] EscFirst  = 8'd92;
   localparam logic [7:0] SpaceCode = 8'd32;
   localparam logic [7:0] AmpCode   = 8'd38;
   localparam logic [7:0] HighFirst = 8'd127;

   localparam logic [2:0] EscDone = 3'(EscLen);

   // work left behind by one input beat: a replayed escape prefix, then an optional tail byte
   typedef struct packed {
      logic [2:0] pre_cnt;
      logic       tail_en;
      logic [7:0] tail_byte;
      logic       last;
   } plan_type;

   typedef struct packed {
      plan_type   plan;
      logic       emit;
      logic [2:0] esc_next;
      logic       lead_next;
   } dec_type;

   function automatic logic [7:0] esc_byte(input logic [2:0] idx);
      logic [7:0] r;
      case (idx)
         3'd0:    r = 8'd92;   // backslash
         3'd1:    r = 8'd117;  // u
         3'd2:    r = 8'd48;
         3'd3:    r = 8'd48;
         3'd4:    r = 8'd50;
         3'd5:    r = 8'd54;
         default: r = 8'd0;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] map_after_lead(input logic [7:0] b);
      logic [7:0] r;
      case (b)
         8'ha4:   r = 8'd127;
         8'h84:   r = 8'd128;
         8'hb6:   r = 8'd129;
         8'h96:   r = 8'd130;
         8'hbc:   r = 8'd131;
         8'h9c:   r = 8'd132;
         8'h9f:   r = 8'd133;
         default: r = SpaceCode;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] map_single(input logic [7:0] b);
      logic [7:0] r;
      if (b < HighFirst) begin
         r = b;
      end else begin
         case (b)
            8'd132:  r = 8'd127;
            8'd142:  r = 8'd128;
            8'd148:  r = 8'd129;
            8'd153:  r = 8'd130;
            8'd129:  r = 8'd131;
            8'd154:  r = 8'd132;
            8'd225:  r = 8'd133;
            default: r = SpaceCode;
         endcase
      end
      return r;
   endfunction

   function automatic dec_type decode(input logic [7:0] b, input logic last,
                                      input logic [2:0] esc_cnt, input logic lead);
      dec_type    d;
      logic [2:0] k;
      logic [2:0] nk;
      k  = (esc_cnt >= EscDone) ? 3'd0 : esc_cnt;
      nk = k + 3'd1;
      d.plan.pre_cnt   = 3'd0;
      d.plan.tail_en   = 1'b0;
      d.plan.tail_byte = SpaceCode;
      d.plan.last      = last;
      d.esc_next       = 3'd0;
      d.lead_next      = 1'b0;
      if (lead) begin
         d.plan.tail_en   = 1'b1;
         d.plan.tail_byte = map_after_lead(b);
      end else if (k != 3'd0 && b == esc_byte(k)) begin
         if (nk == EscDone) begin
            d.plan.tail_en   = 1'b1;
            d.plan.tail_byte = AmpCode;
         end else if (last) begin
            // string ends mid-escape: replay all matched bytes, current one included
            d.plan.pre_cnt = nk;
         end else begin
            d.esc_next = nk;
         end
      end else begin
         d.plan.pre_cnt = k;
         if (b == EscFirst && !last) begin
            d.esc_next = 3'd1;
         end else if (b == LeadByte) begin
            if (last) begin
               d.plan.tail_en = 1'b1;
            end else begin
               d.lead_next = 1'b1;
            end
         end else begin
            d.plan.tail_en   = 1'b1;
            d.plan.tail_byte = map_single(b);
         end
      end
      if (last) begin
         d.esc_next  = 3'd0;
         d.lead_next = 1'b0;
      end
      d.emit = d.plan.tail_en || (d.plan.pre_cnt != 3'd0);
      return d;
   endfunction

endpackage

FILE: rtl/ufont_decode.sv
module ufont_decode (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_in_byte,
   input  logic                req_in_last,
   input  logic                plan_done,
   output logic                plan_valid,
   output ufont_pkg::plan_type plan
);
   import ufont_pkg::*;

   logic [2:0] esc_cnt_ff, esc_cnt_in;
   logic       lead_ff, lead_in;
   logic       plan_valid_ff, plan_valid_in;
   plan_type   plan_ff, plan_in;
   dec_type    dec;
   logic       accept;

   assign req_stall = plan_valid_ff && !plan_done;
   assign accept    = req_valid && !req_stall;
   assign dec       = decode(req_in_byte, req_in_last, esc_cnt_ff, lead_ff);

   always_comb begin
      esc_cnt_in    = esc_cnt_ff;
      lead_in       = lead_ff;
      plan_valid_in = plan_valid_ff && !plan_done;
      plan_in       = plan_ff;
      if (accept) begin
         esc_cnt_in    = dec.esc_next;
         lead_in       = dec.lead_next;
         plan_valid_in = dec.emit;
         plan_in       = dec.plan;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_cnt_ff    <= 3'd0;
         lead_ff       <= 1'b0;
         plan_valid_ff <= 1'b0;
      end else begin
         esc_cnt_ff    <= esc_cnt_in;
         lead_ff       <= lead_in;
         plan_valid_ff <= plan_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      plan_ff <= plan_in;
   end

   assign plan_valid = plan_valid_ff;
   assign plan       = plan_ff;

   a_lead_no_esc: assert property (@(posedge clock) disable iff (reset)
      lead_ff |-> esc_cnt_ff == 3'd0)
      else $error("lead pending while escape match held");

   a_esc_range: assert property (@(posedge clock) disable iff (reset)
      esc_cnt_ff < EscDone)
      else $error("escape match count out of range");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_in_last |=> esc_cnt_ff == 3'd0 && !lead_ff)
      else $error("state not cleared after final beat");

   a_plan_nonempty: assert property (@(posedge clock) disable iff (reset)
      plan_valid_ff |-> plan_ff.tail_en || plan_ff.pre_cnt != 3'd0)
      else $error("empty plan held");

endmodule

FILE: rtl/ufont_emit.sv
module ufont_emit (
   input  logic                clock,
   input  logic                reset,
   input  logic                plan_valid,
   input  ufont_pkg::plan_type plan,
   output logic                plan_done,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_out_last
);
   import ufont_pkg::*;

   logic [2:0] pos_ff, pos_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       out_free;
   logic       fire;
   logic       in_prefix;
   logic       final_el;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = plan_valid && out_free;
   assign in_prefix = pos_ff < plan.pre_cnt;
   assign final_el  = plan.tail_en ? (pos_ff == plan.pre_cnt)
                                   : (pos_ff == plan.pre_cnt - 3'd1);
   assign plan_done = fire && final_el;

   always_comb begin
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (fire) begin
         pos_in       = final_el ? 3'd0 : pos_ff + 3'd1;
         rsp_valid_in = 1'b1;
         rsp_byte_in  = in_prefix ? esc_byte(pos_ff) : plan.tail_byte;
         rsp_last_in  = final_el && plan.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_out_last = rsp_last_ff;

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      plan_valid |-> pos_ff <= plan.pre_cnt)
      else $error("replay position past plan");

   a_pos_wrap: assert property (@(posedge clock) disable iff (reset)
      plan_done |=> pos_ff == 3'd0)
      else $error("replay position not rewound");

   a_idle_pos: assert property (@(posedge clock) disable iff (reset)
      !plan_valid |-> pos_ff == 3'd0)
      else $error("replay position moved without plan");

endmodule

FILE: rtl/umlaut_font_transcoder.sv
// Umlaut font transcoder: byte stream in, display font codes out.
// Request channel (req_valid / req_stall): one text byte per beat, with
// req_in_last on the final byte of a string. Response channel (rsp_valid /
// rsp_stall): transcoded bytes, rsp_out_last on the final one of a string.
// An accepted beat is registered in the decode stage as a plan, then each of
// its response bytes in the response register. Ordinary bytes sustain one
// beat per cycle while the receiver does not stall. A byte that breaks a
// partial \u0026 match replays the held prefix first: it occupies the replay
// stage for up to six response bytes, req_stall high until the last is sent.
// Bytes that only extend a match, or a non-final 195 lead, give no response.
// Reset clears the escape match, the pending lead, the replay stage and the
// response register; no beat is taken in the reset cycle. When the receiver
// stalls, the response register holds its beat and the replay stage backs
// up, so req_stall rises once a plan is waiting.
module umlaut_font_transcoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last
);
   import ufont_pkg::*;

   logic     plan_valid;
   logic     plan_done;
   plan_type plan;

   ufont_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .plan_done   (plan_done),
      .plan_valid  (plan_valid),
      .plan        (plan)
   );

   ufont_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .plan_valid   (plan_valid),
      .plan         (plan),
      .plan_done    (plan_done),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

endmodule

FILE: tb/tb_umlaut_font_transcoder.sv
module tb_umlaut_font_transcoder;
   timeunit 1ns;
   timeprecision 1ps;

   import ufont_pkg::*;

   localparam int Watchdog = 4000;
   localparam int DrainCycles = 16;

   // \u0026, first character in the top byte
   localparam logic [47:0] EscText = {8'd92, 8'd117, 8'd48, 8'd48, 8'd50, 8'd54};
   // second bytes after a 195 lead, and single-byte code page forms, same glyph order
   localparam logic [55:0] Utf8Seconds = {8'ha4, 8'h84, 8'hb6, 8'h96, 8'hbc, 8'h9c, 8'h9f};
   localparam logic [55:0] CodePageForms = {8'd132, 8'd142, 8'd148, 8'd153, 8'd129, 8'd154,
                                            8'd225};

   localparam logic [7:0] GlyphAeSmall = 8'd127;
   localparam logic [7:0] GlyphAeCap   = 8'd128;
   localparam logic [7:0] GlyphOeSmall = 8'd129;
   localparam logic [7:0] GlyphOeCap   = 8'd130;
   localparam logic [7:0] GlyphUeSmall = 8'd131;
   localparam logic [7:0] GlyphUeCap   = 8'd132;
   localparam logic [7:0] GlyphSharpS  = 8'd133;

   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } glyph_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'd0;
   logic       req_in_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_last;

   glyph_beat_type glyph_q[$];
   logic [7:0]     text_q[$];

   logic [2:0] esc_count = 3'd0;
   logic       lead_wait = 1'b0;

   bit req_idle_on = 1'b0;
   bit rsp_idle_on = 1'b0;

   int fail_count = 0;
   int beats_in = 0;
   int beats_out = 0;
   int strings_sent = 0;
   int amp_seen = 0;
   int replay_seen = 0;
   int quiet_cycles = 0;

   umlaut_font_transcoder dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .req_in_last  (req_in_last),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [7:0] esc_char(input logic [2:0] idx);
      return EscText[8 * (5 - idx) +: 8];
   endfunction

   function automatic logic [7:0] utf8_glyph(input logic [7:0] b);
      logic [7:0] g;
      case (b)
         8'ha4:   g = GlyphAeSmall;
         8'h84:   g = GlyphAeCap;
         8'hb6:   g = GlyphOeSmall;
         8'h96:   g = GlyphOeCap;
         8'hbc:   g = GlyphUeSmall;
         8'h9c:   g = GlyphUeCap;
         8'h9f:   g = GlyphSharpS;
         default: g = SpaceCode;
      endcase
      return g;
   endfunction

   function automatic logic [7:0] cp_glyph(input logic [7:0] b);
      logic [7:0] g;
      if (b < HighFirst) begin
         g = b;
      end else begin
         case (b)
            8'd132:  g = GlyphAeSmall;
            8'd142:  g = GlyphAeCap;
            8'd148:  g = GlyphOeSmall;
            8'd153:  g = GlyphOeCap;
            8'd129:  g = GlyphUeSmall;
            8'd154:  g = GlyphUeCap;
            8'd225:  g = GlyphSharpS;
            default: g = SpaceCode;
         endcase
      end
      return g;
   endfunction

   function automatic void push_glyph(input logic [7:0] code, input logic last);
      glyph_beat_type e;
      e.code = code;
      e.last = last;
      glyph_q.push_back(e);
   endfunction

   // expected glyph bytes for one accepted text byte
   function automatic void transcode_byte(input logic [7:0] b, input logic last);
      logic [2:0] k;
      int i;
      k = (esc_count >= EscDone) ? 3'd0 : esc_count;
      if (lead_wait) begin
         lead_wait = 1'b0;
         esc_count = 3'd0;
         push_glyph(utf8_glyph(b), last);
      end else if (k != 3'd0 && b == esc_char(k)) begin
         k = k + 3'd1;
         if (k == EscDone) begin
            esc_count = 3'd0;
            push_glyph(AmpCode, last);
            amp_seen++;
         end else if (last) begin
            // string ends mid-escape: the current byte is replayed with the prefix
            for (i = 0; i < int'(k); i++)
               push_glyph(esc_char(3'(i)), i + 1 == int'(k));
            esc_count = 3'd0;
            replay_seen++;
         end else begin
            esc_count = k;
         end
      end else begin
         for (i = 0; i < int'(k); i++)
            push_glyph(esc_char(3'(i)), 1'b0);
         if (k != 3'd0)
            replay_seen++;
         esc_count = 3'd0;
         if (b == EscFirst && !last) begin
            esc_count = 3'd1;
         end else if (b == LeadByte) begin
            if (last)
               push_glyph(SpaceCode, 1'b1);
            else
               lead_wait = 1'b1;
         end else begin
            push_glyph(cp_glyph(b), last);
         end
      end
      if (last) begin
         esc_count = 3'd0;
         lead_wait = 1'b0;
      end
   endfunction

   task automatic put_text_byte(input logic [7:0] b, input logic last);
      if (req_idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_in_last <= last;
      // stall is settled mid-cycle; the beat goes at the following rising edge
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      transcode_byte(b, last);
      beats_in++;
      if (last)
         strings_sent++;
   endtask

   // sends text_q as one string, last flag on its final byte
   task automatic send_text_q();
      int i;
      for (i = 0; i < text_q.size(); i++)
         put_text_byte(text_q[i], i == text_q.size() - 1);
      text_q.delete();
   endtask

   task automatic test_plain_bytes();
      text_q = '{8'h00, 8'h7e, 8'h7f, 8'hff};
      send_text_q();
   endtask

   task automatic test_code_page();
      text_q = '{8'd132, 8'd225, 8'd200};
      send_text_q();
   endtask

   task automatic test_utf8_lead();
      // a backslash after the lead becomes a space, not taken as an escape
      text_q = '{LeadByte, 8'ha4, LeadByte, EscFirst};
      send_text_q();
      text_q = '{LeadByte};
      send_text_q();
   endtask

   task automatic test_escape();
      text_q = '{8'd92, 8'd117, 8'd48, 8'd48, 8'd50, 8'd54, 8'd65};
      send_text_q();
      // prefix broken by a lead byte
      text_q = '{8'd92, 8'd117, 8'd48, LeadByte, 8'h9f, 8'd54};
      send_text_q();
      text_q = '{8'd92, 8'd117, 8'd48};
      send_text_q();
      // escape completed on the final byte
      text_q = '{8'd92, 8'd117, 8'd48, 8'd48, 8'd50, 8'd54};
      send_text_q();
   endtask

   task automatic test_random_text(input int n_bytes, input bit with_idling);
      int target;
      int n_tok;
      int t;
      int j;
      int plen;
      target = beats_in + n_bytes;
      while (beats_in < target) begin
         req_idle_on = with_idling && $urandom_range(0, 3) != 0;
         rsp_idle_on = with_idling && $urandom_range(0, 3) != 0;
         n_tok = $urandom_range(1, 4);
         for (t = 0; t < n_tok; t++) begin
            case ($urandom_range(0, 11))
               0, 1, 2: text_q.push_back(8'($urandom_range(32, 126)));
               3, 4: begin
                  text_q.push_back(LeadByte);
                  if ($urandom_range(0, 3) == 0)
                     text_q.push_back(8'($urandom_range(0, 255)));
                  else
                     text_q.push_back(Utf8Seconds[8 * $urandom_range(0, 6) +: 8]);
               end
               5, 6: begin
                  if ($urandom_range(0, 3) == 0)
                     text_q.push_back(8'($urandom_range(127, 255)));
                  else
                     text_q.push_back(CodePageForms[8 * $urandom_range(0, 6) +: 8]);
               end
               7: begin
                  for (j = 0; j < 6; j++)
                     text_q.push_back(esc_char(3'(j)));
               end
               8, 9: begin
                  plen = $urandom_range(1, 5);
                  for (j = 0; j < plen; j++)
                     text_q.push_back(esc_char(3'(j)));
                  text_q.push_back(8'($urandom_range(0, 255)));
               end
               default: text_q.push_back(8'($urandom_range(0, 255)));
            endcase
         end
         send_text_q();
      end
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
   endtask

   // receiver back-pressure in bursts
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // handshakes are looked at mid-cycle, where they hold for the coming edge
   always @(negedge clock) begin
      glyph_beat_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_out++;
         if (glyph_q.size() == 0) begin
            $error("unexpected beat: out_byte %0d out_last %0d", rsp_out_byte, rsp_out_last);
            fail_count++;
         end else begin
            e = glyph_q.pop_front();
            if (rsp_out_byte !== e.code) begin
               $error("out_byte: expected %0d, got %0d", e.code, rsp_out_byte);
               fail_count++;
            end
            if (rsp_out_last !== e.last) begin
               $error("out_last: expected %0d, got %0d", e.last, rsp_out_last);
               fail_count++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= Watchdog) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_plain_bytes();
      test_code_page();
      test_utf8_lead();
      test_escape();
      test_random_text(260, 1'b1);
      test_random_text(60, 1'b0);
      req_valid <= 1'b0;

      while (glyph_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("tb: %0d text bytes in %0d strings, %0d glyph bytes checked",
               beats_in, strings_sent, beats_out);
      $display("tb: %0d escapes decoded, %0d partial escapes replayed", amp_seen, replay_seen);
      if (fail_count == 0 && glyph_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
